@@ rtl/kts_pkg.sv @@
// Package for the top-k score table: field types, codes, constants and the score compare.
`default_nettype none
package kts_pkg;

	localparam int unsigned TABLE_DEPTH  = 16;
	localparam int unsigned SCORE_BITS   = 32;
	localparam int unsigned PAYLOAD_BITS = 64;
	localparam int unsigned INDEX_BITS   = 4;
	localparam int unsigned COUNT_BITS   = 5;
	localparam int unsigned CFG_DATA_BITS = 5;

	typedef logic [INDEX_BITS-1:0]          kts_index_t;
	typedef logic [COUNT_BITS-1:0]          kts_count_t;
	typedef logic signed [SCORE_BITS-1:0]   kts_score_t;
	typedef logic [PAYLOAD_BITS-1:0]        kts_payload_t;

	// Item operation codes
	typedef enum logic [1:0] {
		MODE_NOMINATE  = 2'd0,
		MODE_SET_SCORE = 2'd1,
		MODE_READ      = 2'd2,
		MODE_NOP       = 2'd3
	} kts_mode_t;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_PREFER_HIGH  = 1'b0,
		CFG_ACTIVE_LIMIT = 1'b1
	} kts_cfg_index_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_WSCAN,
		ST_WDRAIN,
		ST_REPLACE,
		ST_SCAN,
		ST_SDRAIN,
		ST_DONE
	} kts_state_t;

	typedef struct packed {
		kts_mode_t    mode;
		kts_index_t   entry_index;
		kts_score_t   new_score;
		kts_payload_t payload_in;
	} kts_in_t;

	typedef struct packed {
		kts_count_t   entry_count;
		kts_index_t   best_index;
		kts_score_t   best_score;
		kts_index_t   worst_index;
		kts_score_t   worst_score;
		kts_payload_t payload_out;
		logic         stored;
		logic         index_error;
	} kts_out_t;

	// Control from the sequencer to the scan unit for one score read
	typedef struct packed {
		logic       vld;
		logic       first;
		kts_index_t idx;
	} kts_scan_ctl_t;

	// a is at least as good as b under the current preference
	function automatic logic as_good(kts_score_t a, kts_score_t b, logic prefer_high);
		logic result;
		result = prefer_high ? (a >= b) : (a <= b);
		return result;
	endfunction

	// a is at least as bad as b under the current preference
	function automatic logic as_bad(kts_score_t a, kts_score_t b, logic prefer_high);
		logic result;
		result = prefer_high ? (a <= b) : (a >= b);
		return result;
	endfunction

endpackage
`default_nettype wire

@@ rtl/kts_store.sv @@
// Score and payload storage of the top-k score table, one write and one registered read port.
`default_nettype none
module kts_store
	import kts_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         we_score,
	input  wire logic         we_payload,
	input  wire kts_index_t   waddr,
	input  wire kts_score_t   wscore,
	input  wire kts_payload_t wpayload,
	input  wire kts_index_t   raddr,
	output kts_score_t        rscore,
	output kts_payload_t      rpayload
);

	kts_score_t   score_mem   [TABLE_DEPTH];
	kts_payload_t payload_mem [TABLE_DEPTH];
	kts_score_t   rscore_q;
	kts_payload_t rpayload_q;

	// Writes
	always_ff @(posedge clk) begin
		if (we_score) begin
			score_mem[waddr] <= wscore;
		end
		if (we_payload) begin
			payload_mem[waddr] <= wpayload;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rscore_q   <= score_mem[raddr];
		rpayload_q <= payload_mem[raddr];
	end

	assign rscore   = rscore_q;
	assign rpayload = rpayload_q;

endmodule
`default_nettype wire

@@ rtl/kts_scan.sv @@
// Shared compare unit: tracks best and worst entries over a scan in index order.
`default_nettype none
module kts_scan
	import kts_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          prefer_high,
	input  wire kts_scan_ctl_t ctl,
	input  wire kts_score_t    score,
	output kts_index_t         best_index,
	output kts_score_t         best_score,
	output kts_index_t         worst_index,
	output kts_score_t         worst_score
);

	kts_index_t best_idx_q;
	kts_index_t worst_idx_q;
	kts_score_t best_q;
	kts_score_t worst_q;
	logic       take_best;
	logic       take_worst;

	// Later index wins on ties, first entry loads both
	assign take_best  = ctl.first || as_good(score, best_q, prefer_high);
	assign take_worst = ctl.first || as_bad(score, worst_q, prefer_high);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_idx_q  <= '0;
			worst_idx_q <= '0;
		end else if (ctl.vld) begin
			if (take_best) begin
				best_idx_q <= ctl.idx;
			end
			if (take_worst) begin
				worst_idx_q <= ctl.idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			if (take_best) begin
				best_q <= score;
			end
			if (take_worst) begin
				worst_q <= score;
			end
		end
	end

	assign best_index  = best_idx_q;
	assign best_score  = best_q;
	assign worst_index = worst_idx_q;
	assign worst_score = worst_q;

endmodule
`default_nettype wire

@@ rtl/top_k_score_table_unit.sv @@
// Top level of the top-k score table: sequencer, configuration registers and result port.
//
// Adds (score, payload) entries up to clamped active_limit, favoring high or low scores.
// Command channel: an item is taken at a clock edge with start high and busy low;
// busy stays high until the result has been shown. Each item gives one result,
// shown for exactly one cycle with result_valid high; the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
// prefer_high, index 1 is active_limit. Write only while busy is low.
// Each item scans the filled table one entry per cycle through the registered
// read port of the score store and the shared compare unit; an empty table is
// not scanned, a read item with a valid index first waits for its payload read,
// and a nomination into a full table first scans for the worst entry, then scans
// once more. The next item can be taken in the cycle after the result cycle.
// Reset clears the fill count, sets prefer_high to 1 and active_limit to 16.
// No clearing pass is needed: only filled entries are ever read.
`default_nettype none
module top_k_score_table_unit
	import kts_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire kts_in_t        item,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire kts_cfg_index_t cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                result_valid,
	output kts_out_t            result
);

	kts_state_t    state_q, state_d;
	kts_in_t       item_q;
	kts_count_t    fill_q;
	kts_index_t    scan_cnt_q;
	logic          prefer_high_q;
	kts_count_t    active_limit_q;
	logic          stored_q;
	logic          err_q;
	kts_payload_t  pay_q;
	kts_scan_ctl_t ctl_s1;

	kts_count_t    limit;
	logic          idx_bad;
	logic          scan_last;
	logic          we_score, we_payload;
	kts_index_t    waddr, raddr;
	logic          issue, cnt_inc, cnt_clr, fill_inc, set_stored, set_err, cap_pay;
	kts_score_t    rscore;
	kts_payload_t  rpayload;
	kts_index_t    best_index, worst_index;
	kts_score_t    best_score, worst_score;

	// Limit clamped to 1..TABLE_DEPTH
	always_comb begin
		if (active_limit_q == '0) begin
			limit = kts_count_t'(1);
		end else if (active_limit_q > kts_count_t'(TABLE_DEPTH)) begin
			limit = kts_count_t'(TABLE_DEPTH);
		end else begin
			limit = active_limit_q;
		end
	end

	assign idx_bad   = {1'b0, item_q.entry_index} >= fill_q;
	assign scan_last = {1'b0, scan_cnt_q} == (fill_q - kts_count_t'(1));

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefer_high_q  <= 1'b1;
			active_limit_q <= kts_count_t'(TABLE_DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PREFER_HIGH:  prefer_high_q  <= cfg_data[0];
				CFG_ACTIVE_LIMIT: active_limit_q <= kts_count_t'(cfg_data);
			endcase
		end
	end

	// Sequencer: next state and control
	always_comb begin
		state_d    = state_q;
		we_score   = 1'b0;
		we_payload = 1'b0;
		waddr      = fill_q[INDEX_BITS-1:0];
		raddr      = scan_cnt_q;
		issue      = 1'b0;
		cnt_inc    = 1'b0;
		cnt_clr    = 1'b0;
		fill_inc   = 1'b0;
		set_stored = 1'b0;
		set_err    = 1'b0;
		cap_pay    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (item_q.mode)
					MODE_NOMINATE: begin
						if (fill_q < limit) begin
							we_score   = 1'b1;
							we_payload = 1'b1;
							fill_inc   = 1'b1;
							set_stored = 1'b1;
							state_d    = ST_SCAN;
						end else begin
							state_d = ST_WSCAN;
						end
					end
					MODE_SET_SCORE: begin
						if (idx_bad) begin
							set_err = 1'b1;
						end else begin
							we_score = 1'b1;
							waddr    = item_q.entry_index;
						end
						state_d = ST_SCAN;
					end
					MODE_READ: begin
						if (idx_bad) begin
							set_err = 1'b1;
							state_d = ST_SCAN;
						end else begin
							raddr   = item_q.entry_index;
							state_d = ST_RDWAIT;
						end
					end
					MODE_NOP: begin
						state_d = ST_SCAN;
					end
				endcase
			end
			ST_RDWAIT: begin
				cap_pay = 1'b1;
				state_d = ST_SCAN;
			end
			ST_WSCAN, ST_SCAN: begin
				priority if (fill_q == '0) begin
					state_d = ST_DONE;
				end else if (scan_last) begin
					issue   = 1'b1;
					cnt_clr = 1'b1;
					state_d = (state_q == ST_WSCAN) ? ST_WDRAIN : ST_SDRAIN;
				end else begin
					issue   = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			ST_WDRAIN: begin
				state_d = ST_REPLACE;
			end
			ST_REPLACE: begin
				if (as_good(item_q.new_score, worst_score, prefer_high_q)) begin
					we_score   = 1'b1;
					we_payload = 1'b1;
					waddr      = worst_index;
					set_stored = 1'b1;
				end
				state_d = ST_SCAN;
			end
			ST_SDRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			scan_cnt_q <= '0;
			stored_q   <= 1'b0;
			err_q      <= 1'b0;
			ctl_s1     <= '0;
		end else begin
			state_q <= state_d;
			if (fill_inc) begin
				fill_q <= fill_q + kts_count_t'(1);
			end
			if (cnt_clr) begin
				scan_cnt_q <= '0;
			end else if (cnt_inc) begin
				scan_cnt_q <= scan_cnt_q + kts_index_t'(1);
			end
			if (start && !busy) begin
				stored_q <= 1'b0;
				err_q    <= 1'b0;
			end else begin
				if (set_stored) begin
					stored_q <= 1'b1;
				end
				if (set_err) begin
					err_q <= 1'b1;
				end
			end
			ctl_s1.vld   <= issue;
			ctl_s1.first <= issue && (scan_cnt_q == '0);
			ctl_s1.idx   <= scan_cnt_q;
		end
	end

	// Item and read payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
			pay_q  <= '0;
		end else if (cap_pay) begin
			pay_q <= rpayload;
		end
	end

	kts_store u_store (
		.clk        (clk),
		.we_score   (we_score),
		.we_payload (we_payload),
		.waddr      (waddr),
		.wscore     (item_q.new_score),
		.wpayload   (item_q.payload_in),
		.raddr      (raddr),
		.rscore     (rscore),
		.rpayload   (rpayload)
	);

	kts_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.prefer_high (prefer_high_q),
		.ctl         (ctl_s1),
		.score       (rscore),
		.best_index  (best_index),
		.best_score  (best_score),
		.worst_index (worst_index),
		.worst_score (worst_score)
	);

	// Result port
	assign busy         = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DONE);

	always_comb begin
		result.entry_count = fill_q;
		result.payload_out = pay_q;
		result.stored      = stored_q;
		result.index_error = err_q;
		if (fill_q == '0) begin
			result.best_index  = '0;
			result.best_score  = '0;
			result.worst_index = '0;
			result.worst_score = '0;
		end else begin
			result.best_index  = best_index;
			result.best_score  = best_score;
			result.worst_index = worst_index;
			result.worst_score = worst_score;
		end
	end

endmodule
`default_nettype wire

@@ sim/kts_rank_monitor.sv @@
// Monitor for the top-k score table: predicts each item's status and compares it with the result port.
module kts_rank_monitor
	import kts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  kts_in_t                  item,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  kts_cfg_index_t           cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     result_valid,
	input  kts_out_t                 result,
	output int                       mismatches,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Mirror of the table and its registers
	kts_score_t               score_mem [TABLE_DEPTH];
	kts_payload_t             payload_mem [TABLE_DEPTH];
	int unsigned              fill;
	logic                     prefer_high_r;
	logic [CFG_DATA_BITS-1:0] limit_r;

	// Status expected for each accepted transaction, oldest first
	kts_out_t status_q[$];

	// a ranks at least as well as b under the current preference
	function automatic bit ranks_over(kts_score_t a, kts_score_t b);
		return prefer_high_r ? (a >= b) : (a <= b);
	endfunction

	// Scan the filled entries in index order; the later index wins a tie
	function automatic int unsigned scan_pick(bit want_best);
		int unsigned pick;
		pick = 0;
		for (int unsigned i = 1; i < fill; i++) begin
			if (want_best ? ranks_over(score_mem[i], score_mem[pick])
				: ranks_over(score_mem[pick], score_mem[i]))
				pick = i;
		end
		return pick;
	endfunction

	// Update the mirror for one item and return the status it reports
	function automatic kts_out_t apply_item(kts_in_t it);
		int unsigned lim;
		int unsigned b;
		int unsigned w;
		kts_out_t    r;
		r = '0;
		lim = limit_r;
		if (lim < 1)
			lim = 1;
		if (lim > TABLE_DEPTH)
			lim = TABLE_DEPTH;
		case (it.mode)
			MODE_NOMINATE: begin
				if (fill < lim) begin
					score_mem[fill] = it.new_score;
					payload_mem[fill] = it.payload_in;
					fill++;
					r.stored = 1'b1;
				end else if (fill > 0) begin
					// full table: replace the worst entry if the new score ranks at least as well
					w = scan_pick(1'b0);
					if (ranks_over(it.new_score, score_mem[w])) begin
						score_mem[w] = it.new_score;
						payload_mem[w] = it.payload_in;
						r.stored = 1'b1;
					end
				end
			end
			MODE_SET_SCORE, MODE_READ: begin
				if (it.entry_index >= fill)
					r.index_error = 1'b1;
				else if (it.mode == MODE_SET_SCORE)
					score_mem[it.entry_index] = it.new_score;
				else
					r.payload_out = payload_mem[it.entry_index];
			end
			default: ;
		endcase
		r.entry_count = kts_count_t'(fill);
		if (fill > 0) begin
			b = scan_pick(1'b1);
			w = scan_pick(1'b0);
			r.best_index = kts_index_t'(b);
			r.best_score = score_mem[b];
			r.worst_index = kts_index_t'(w);
			r.worst_score = score_mem[w];
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t ns: MISMATCH %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// Result compare, then register writes, then prediction, at each clock edge
	always @(posedge clk or negedge arst_n) begin
		kts_out_t want;
		if (!arst_n) begin
			status_q.delete();
			fill = 0;
			prefer_high_r = 1'b1;
			limit_r = CFG_DATA_BITS'(TABLE_DEPTH);
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (result_valid) begin
				if (status_q.size() == 0) begin
					report_mismatch("result with no transaction pending");
				end else begin
					want = status_q.pop_front();
					check_field("entry_count", result.entry_count, want.entry_count);
					check_field("best_index", result.best_index, want.best_index);
					check_field("best_score", result.best_score, want.best_score);
					check_field("worst_index", result.worst_index, want.worst_index);
					check_field("worst_score", result.worst_score, want.worst_score);
					check_field("payload_out", result.payload_out, want.payload_out);
					check_field("stored", result.stored, want.stored);
					check_field("index_error", result.index_error, want.index_error);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PREFER_HIGH:  prefer_high_r = cfg_data[0];
					CFG_ACTIVE_LIMIT: limit_r = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				status_q.push_back(apply_item(item));
			outstanding = status_q.size();
		end
	end

endmodule

@@ sim/tb_top_k_score_table_unit.sv @@
// Testbench top for the top-k score table: clock, reset, stimulus, watchdog and verdict.
module tb_top_k_score_table_unit;
	import kts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         QUIET_LIMIT = 1000;
	localparam kts_score_t SCORE_MAX   = {1'b0, {(SCORE_BITS-1){1'b1}}};
	localparam kts_score_t SCORE_MIN   = {1'b1, {(SCORE_BITS-1){1'b0}}};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	kts_in_t                  item = '0;
	logic                     cfg_valid = 1'b0;
	kts_cfg_index_t           cfg_index = CFG_PREFER_HIGH;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     busy;
	logic                     cfg_ready;
	logic                     result_valid;
	kts_out_t                 result;
	int                       mismatches;
	int                       outstanding;
	int                       sender_idle_pct = 0;
	int                       quiet_cycles = 0;

	always #4 clk = ~clk;

	top_k_score_table_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	kts_rank_monitor u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Watchdog: cycles in which no transaction of any kind completes
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("top_k_score_table_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic bit sender_go();
		return $urandom_range(99) >= sender_idle_pct;
	endfunction

	function automatic kts_in_t mk(kts_mode_t m, int unsigned idx, kts_score_t s,
		kts_payload_t p);
		kts_in_t it;
		it.mode = m;
		it.entry_index = kts_index_t'(idx);
		it.new_score = s;
		it.payload_in = p;
		return it;
	endfunction

	// Present one item; start may drop on idle cycles until the block takes it
	task automatic send_item(input kts_in_t it);
		bit taken;
		taken = 0;
		item <= it;
		start <= sender_go();
		while (!taken) begin
			@(posedge clk);
			if (start && !busy)
				taken = 1;
			else
				start <= sender_go();
		end
	endtask

	// Hold off until every pending result has come and the block is free
	task automatic wait_idle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0 || busy);
		@(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic set_config(bit prefer, logic [CFG_DATA_BITS-1:0] lim);
		logic [CFG_DATA_BITS-1:0] pdata;
		pdata = CFG_DATA_BITS'($urandom);
		pdata[0] = prefer;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_PREFER_HIGH;
		cfg_data <= pdata;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_index <= CFG_ACTIVE_LIMIT;
		cfg_data <= lim;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One random phase under a given setting and sender idle rate
	task automatic random_phase(bit prefer, logic [CFG_DATA_BITS-1:0] lim, int idle, int count);
		kts_in_t     it;
		int unsigned r;
		int unsigned span;
		set_config(prefer, lim);
		sender_idle_pct = idle;
		span = (lim == 0) ? 1 : (lim > TABLE_DEPTH) ? TABLE_DEPTH : lim;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 50)
				it.mode = MODE_NOMINATE;
			else if (r < 70)
				it.mode = MODE_SET_SCORE;
			else if (r < 90)
				it.mode = MODE_READ;
			else
				it.mode = MODE_NOP;
			// mostly indexes inside the table, some anywhere
			if ($urandom_range(3) != 0)
				it.entry_index = kts_index_t'($urandom_range(span - 1));
			else
				it.entry_index = kts_index_t'($urandom);
			// narrow range gives plenty of ties
			r = $urandom_range(99);
			if (r < 35) begin
				it.new_score = kts_score_t'($urandom_range(6)) - 3;
			end else if (r < 45) begin
				case ($urandom_range(3))
					0: it.new_score = SCORE_MAX;
					1: it.new_score = SCORE_MIN;
					2: it.new_score = '1;
					default: it.new_score = '0;
				endcase
			end else begin
				it.new_score = kts_score_t'($urandom);
			end
			r = $urandom_range(99);
			if (r < 10)
				it.payload_in = '1;
			else if (r < 15)
				it.payload_in = '0;
			else
				it.payload_in = {$urandom, $urandom};
			if ($urandom_range(99) < 2)
				wait_idle();
			send_item(it);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, bad indexes, no-op, extremes and ties under reset settings
		send_item(mk(MODE_READ, 0, 0, '1));
		send_item(mk(MODE_SET_SCORE, 15, 5, '0));
		send_item(mk(MODE_NOP, 15, '1, '1));
		send_item(mk(MODE_NOMINATE, 15, SCORE_MAX, '1));
		send_item(mk(MODE_NOMINATE, 0, SCORE_MIN, '0));
		send_item(mk(MODE_NOMINATE, 7, 0, 64'h0123_4567_89ab_cdef));
		send_item(mk(MODE_NOMINATE, 3, SCORE_MAX, 64'hfedc_ba98_7654_3210));
		send_item(mk(MODE_READ, 0, SCORE_MIN, 64'h5555_aaaa_5555_aaaa));
		send_item(mk(MODE_READ, 3, 0, '0));
		send_item(mk(MODE_READ, 4, 0, '0));
		send_item(mk(MODE_SET_SCORE, 1, SCORE_MAX, '1));
		send_item(mk(MODE_SET_SCORE, 15, 1, '0));
		send_item(mk(MODE_NOP, 0, 0, '0));

		// Limit below the count: nominations take the replace path
		set_config(1'b1, 2);
		send_item(mk(MODE_NOMINATE, 0, SCORE_MIN, 64'h1));
		send_item(mk(MODE_NOMINATE, 0, 0, 64'h2));
		send_item(mk(MODE_NOMINATE, 0, 7, 64'h3));

		// Low scores preferred, limit zero acts as one
		set_config(1'b0, 0);
		send_item(mk(MODE_NOMINATE, 9, SCORE_MIN, 64'h4));
		send_item(mk(MODE_NOMINATE, 9, SCORE_MAX, 64'h5));
		send_item(mk(MODE_READ, 3, 0, '0));

		// Limit above the depth acts as the depth
		set_config(1'b1, 31);
		send_item(mk(MODE_NOMINATE, 0, '1, 64'h8000_0000_0000_0001));
		send_item(mk(MODE_SET_SCORE, 4, SCORE_MIN, '0));
		send_item(mk(MODE_READ, 4, 0, '0));

		// Random phases over several settings and sender idle rates
		random_phase(1'b1, 16, 0, 125);
		random_phase(1'b0, 16, 69, 125);
		random_phase(1'b1, 5, 12, 125);
		random_phase(1'b0, 2, 0, 125);
		random_phase(1'b1, 1, 69, 125);
		random_phase(1'b0, 0, 12, 125);
		random_phase(1'b1, 31, 0, 125);
		random_phase(1'b0, 17, 69, 125);
		random_phase(1'b1, 12, 12, 125);
		random_phase(1'($urandom_range(1)), CFG_DATA_BITS'($urandom_range(31)), 0, 125);

		// Drain, then allow the block its longest item time
		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("top_k_score_table_unit regression: pass");
		else
			$display("top_k_score_table_unit regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/kts_pkg.sv
rtl/kts_store.sv
rtl/kts_scan.sv
rtl/top_k_score_table_unit.sv
sim/kts_rank_monitor.sv
sim/tb_top_k_score_table_unit.sv
